/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define NECIRTX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked at every clock edge outside reset
`define NECIRTX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/necirtx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necirtx_pkg
// Types, phase codes and register map of the infrared frame transmitter.
// ----------------------------------------------------------------------------
package necirtx_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned TickW   = 14;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned LeftW   = 6;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned LzW     = 5;

  // Sequence phases
  localparam logic [PhaseW-1:0] PH_IDLE           = 4'd0;
  localparam logic [PhaseW-1:0] PH_LEAD_MARK      = 4'd1;
  localparam logic [PhaseW-1:0] PH_LEAD_SPACE     = 4'd2;
  localparam logic [PhaseW-1:0] PH_BIT_MARK       = 4'd3;
  localparam logic [PhaseW-1:0] PH_BIT_SPACE      = 4'd4;
  localparam logic [PhaseW-1:0] PH_STOP_MARK      = 4'd5;
  localparam logic [PhaseW-1:0] PH_STOP_SPACE     = 4'd6;
  localparam logic [PhaseW-1:0] PH_GAP            = 4'd7;
  localparam logic [PhaseW-1:0] PH_REP_MARK       = 4'd8;
  localparam logic [PhaseW-1:0] PH_REP_SPACE      = 4'd9;
  localparam logic [PhaseW-1:0] PH_REP_STOP_MARK  = 4'd10;
  localparam logic [PhaseW-1:0] PH_REP_STOP_SPACE = 4'd11;
  localparam logic [PhaseW-1:0] PH_END_PAUSE      = 4'd12;

  // Fixed length of the repeat mark
  localparam logic [TickW-1:0] RepMarkTicks = 14'd890;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [RegIdxW-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ONE_EXTRA    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_REPEAT_GAP   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_REPEAT_SPACE = 3'd6;
  localparam logic [RegIdxW-1:0] REG_END_PAUSE    = 3'd7;

  // Timing registers
  typedef struct packed {
    logic [9:0]  leader_mark_ticks;
    logic [9:0]  leader_space_ticks;
    logic [7:0]  bit_mark_ticks;
    logic [7:0]  zero_space_ticks;
    logic [7:0]  one_extra_ticks;
    logic [12:0] repeat_gap_ticks;
    logic [9:0]  repeat_space_ticks;
    logic [13:0] end_pause_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    leader_mark_ticks:  10'd885,
    leader_space_ticks: 10'd445,
    bit_mark_ticks:     8'd52,
    zero_space_ticks:   8'd51,
    one_extra_ticks:    8'd103,
    repeat_gap_ticks:   13'd3900,
    repeat_space_ticks: 10'd210,
    end_pause_ticks:    14'd9500
  };

  // Result of one item
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic start_rejected;
    logic sequence_done;
  } result_t;

endpackage

/* hw/rtl/necirtx_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necirtx_if
// Valid/ready channels of the transmitter: items in, results out, register
// writes.
// ----------------------------------------------------------------------------
interface necirtx_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [necirtx_pkg::ByteW-1:0]  device_address;
  logic [necirtx_pkg::ByteW-1:0]  key_code;

  modport source (output valid, cmd, device_address, key_code, input ready);
  modport sink   (input valid, cmd, device_address, key_code, output ready);
endinterface

interface necirtx_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic start_rejected;
  logic sequence_done;

  modport source (output valid, carrier_on, busy_res, start_rejected, sequence_done,
                  input ready);
  modport sink   (input valid, carrier_on, busy_res, start_rejected, sequence_done,
                  output ready);
endinterface

interface necirtx_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [necirtx_pkg::RegIdxW-1:0]   index;
  logic [necirtx_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/necirtx_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necirtx_engine
// Sequence state and next-segment search: one item updates the state and
// yields its result in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module necirtx_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          cmd_i,
  input  logic [necirtx_pkg::ByteW-1:0] device_address_i,
  input  logic [necirtx_pkg::ByteW-1:0] key_code_i,
  input  necirtx_pkg::cfg_t             cfg_i,
  output necirtx_pkg::result_t          result_o
);

  localparam int unsigned TickW  = necirtx_pkg::TickW;
  localparam int unsigned FrameW = necirtx_pkg::FrameW;
  localparam int unsigned LeftW  = necirtx_pkg::LeftW;
  localparam int unsigned PhaseW = necirtx_pkg::PhaseW;
  localparam int unsigned LzW    = necirtx_pkg::LzW;

  // Carrier is on in every mark phase
  function automatic logic mark_level(logic [PhaseW-1:0] ph);
    mark_level = (ph == necirtx_pkg::PH_LEAD_MARK) || (ph == necirtx_pkg::PH_BIT_MARK) ||
                 (ph == necirtx_pkg::PH_STOP_MARK) || (ph == necirtx_pkg::PH_REP_MARK) ||
                 (ph == necirtx_pkg::PH_REP_STOP_MARK);
  endfunction

  // Zeros above the highest set bit
  function automatic logic [LzW-1:0] lead_zeros(logic [FrameW-1:0] v);
    logic [LzW-1:0] n;
    n = '0;
    for (int i = 0; i < FrameW; i++) begin
      if (v[i]) n = LzW'(FrameW - 1 - i);
    end
    lead_zeros = n;
  endfunction

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [FrameW-1:0] bits_q, bits_d;
  logic [LeftW-1:0]  left_q, left_d;

  logic [TickW-1:0]  tick_dec;
  logic [PhaseW-1:0] srch_ph;
  logic [FrameW-1:0] srch_bits;
  logic [LeftW-1:0]  srch_left;

  logic              hunt;
  logic [8:0]        bit_len;
  logic [FrameW-1:0] sh_bits;
  logic [LeftW-1:0]  sh_left;
  logic [LzW-1:0]    lz;
  logic [PhaseW-1:0] seg_ph;
  logic [TickW-1:0]  seg_ticks;
  logic [FrameW-1:0] seg_bits;
  logic [LeftW-1:0]  seg_left;

  // Pick the phase that follows the current one, or the leader on a start
  always_comb begin
    tick_dec  = tick_q - TickW'(tick_q != '0);
    srch_bits = bits_q;
    srch_left = left_q;
    if (cmd_i) begin
      srch_ph   = necirtx_pkg::PH_LEAD_MARK;
      srch_bits = {device_address_i, ~device_address_i, key_code_i, ~key_code_i};
      srch_left = LeftW'(FrameW);
    end else if (phase_q == necirtx_pkg::PH_IDLE || phase_q >= necirtx_pkg::PH_END_PAUSE) begin
      srch_ph = necirtx_pkg::PH_IDLE;
    end else if (phase_q == necirtx_pkg::PH_LEAD_SPACE) begin
      srch_ph = necirtx_pkg::PH_BIT_MARK;
    end else if (phase_q == necirtx_pkg::PH_BIT_SPACE) begin
      srch_ph   = necirtx_pkg::PH_BIT_MARK;
      srch_bits = bits_q << 1;
      srch_left = (left_q != '0) ? left_q - LeftW'(1) : '0;
    end else begin
      srch_ph = phase_q + PhaseW'(1);
    end
  end

  // Find the first segment of non-zero length from srch_ph onwards
  always_comb begin
    hunt      = (srch_ph != necirtx_pkg::PH_IDLE);
    seg_ph    = necirtx_pkg::PH_IDLE;
    seg_ticks = '0;
    seg_bits  = srch_bits;
    seg_left  = srch_left;
    bit_len   = {1'b0, cfg_i.zero_space_ticks} +
                (srch_bits[FrameW-1] ? {1'b0, cfg_i.one_extra_ticks} : 9'd0);
    sh_bits   = srch_bits << 1;
    sh_left   = srch_left - LeftW'(srch_left != '0);
    lz        = lead_zeros(sh_bits);

    // leader
    if (hunt && srch_ph == necirtx_pkg::PH_LEAD_MARK && cfg_i.leader_mark_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_LEAD_MARK;
      seg_ticks = TickW'(cfg_i.leader_mark_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_LEAD_SPACE && cfg_i.leader_space_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_LEAD_SPACE;
      seg_ticks = TickW'(cfg_i.leader_space_ticks);
      hunt      = 1'b0;
    end

    // data bits; a run of empty bits is skipped up to the next one bit
    if (hunt && srch_ph <= necirtx_pkg::PH_BIT_SPACE && srch_left != '0) begin
      if (srch_ph <= necirtx_pkg::PH_BIT_MARK && cfg_i.bit_mark_ticks != '0) begin
        seg_ph    = necirtx_pkg::PH_BIT_MARK;
        seg_ticks = TickW'(cfg_i.bit_mark_ticks);
        hunt      = 1'b0;
      end else if (bit_len != '0) begin
        seg_ph    = necirtx_pkg::PH_BIT_SPACE;
        seg_ticks = TickW'(bit_len);
        hunt      = 1'b0;
      end else if (sh_left != '0) begin
        if (cfg_i.bit_mark_ticks != '0) begin
          seg_ph    = necirtx_pkg::PH_BIT_MARK;
          seg_ticks = TickW'(cfg_i.bit_mark_ticks);
          seg_bits  = sh_bits;
          seg_left  = sh_left;
          hunt      = 1'b0;
        end else if (cfg_i.one_extra_ticks != '0 && sh_bits != '0) begin
          seg_ph    = necirtx_pkg::PH_BIT_SPACE;
          seg_ticks = TickW'(cfg_i.one_extra_ticks);
          seg_bits  = sh_bits << lz;
          seg_left  = sh_left - LeftW'(lz);
          hunt      = 1'b0;
        end
      end
    end

    // stop bit, gap and repeat mark
    if (hunt && srch_ph <= necirtx_pkg::PH_STOP_MARK && cfg_i.bit_mark_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_STOP_MARK;
      seg_ticks = TickW'(cfg_i.bit_mark_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_STOP_SPACE && cfg_i.zero_space_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_STOP_SPACE;
      seg_ticks = TickW'(cfg_i.zero_space_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_GAP && cfg_i.repeat_gap_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_GAP;
      seg_ticks = TickW'(cfg_i.repeat_gap_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_REP_MARK) begin
      seg_ph    = necirtx_pkg::PH_REP_MARK;
      seg_ticks = necirtx_pkg::RepMarkTicks;
      hunt      = 1'b0;
    end

    // repeat tail and closing pause
    if (hunt && srch_ph <= necirtx_pkg::PH_REP_SPACE && cfg_i.repeat_space_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_REP_SPACE;
      seg_ticks = TickW'(cfg_i.repeat_space_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_REP_STOP_MARK && cfg_i.bit_mark_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_REP_STOP_MARK;
      seg_ticks = TickW'(cfg_i.bit_mark_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_REP_STOP_SPACE && cfg_i.zero_space_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_REP_STOP_SPACE;
      seg_ticks = TickW'(cfg_i.zero_space_ticks);
      hunt      = 1'b0;
    end
    if (hunt && srch_ph <= necirtx_pkg::PH_END_PAUSE && cfg_i.end_pause_ticks != '0) begin
      seg_ph    = necirtx_pkg::PH_END_PAUSE;
      seg_ticks = TickW'(cfg_i.end_pause_ticks);
    end
  end

  // Apply one item: start, reject, or count a tick
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bits_d   = bits_q;
    left_d   = left_q;
    result_o = '0;
    if (step_i) begin
      if (cmd_i) begin
        if (phase_q != necirtx_pkg::PH_IDLE) begin
          result_o.carrier_on     = mark_level(phase_q);
          result_o.busy_res       = 1'b1;
          result_o.start_rejected = 1'b1;
        end else begin
          phase_d = seg_ph;
          tick_d  = seg_ticks;
          bits_d  = seg_bits;
          left_d  = seg_left;
          result_o.carrier_on    = mark_level(seg_ph);
          result_o.busy_res      = (seg_ph != necirtx_pkg::PH_IDLE);
          result_o.sequence_done = (seg_ph == necirtx_pkg::PH_IDLE);
        end
      end else if (phase_q != necirtx_pkg::PH_IDLE) begin
        result_o.carrier_on = mark_level(phase_q);
        result_o.busy_res   = 1'b1;
        if (tick_dec == '0) begin
          phase_d = seg_ph;
          tick_d  = seg_ticks;
          bits_d  = seg_bits;
          left_d  = seg_left;
          result_o.sequence_done = (seg_ph == necirtx_pkg::PH_IDLE);
        end else begin
          tick_d = tick_dec;
        end
      end
    end
  end

  // Hold the sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= necirtx_pkg::PH_IDLE;
      tick_q  <= '0;
      bits_q  <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      left_q  <= left_d;
    end
  end

  `NECIRTX_ASSERT(a_tick_live, (phase_q == necirtx_pkg::PH_IDLE) == (tick_q == '0), "tick count does not match phase")
  `NECIRTX_ASSERT(a_left_range, left_q <= LeftW'(FrameW), "bit count beyond frame length")
  `NECIRTX_ASSERT_IMP(a_bits_pending, (phase_q == necirtx_pkg::PH_BIT_MARK) || (phase_q == necirtx_pkg::PH_BIT_SPACE), left_q != '0, "data bit phase with no bits left")

endmodule

/* hw/rtl/nec_ir_frame_transmitter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_unit
// Pulse-distance infrared frame transmitter driven by 10 us tick items.
// ----------------------------------------------------------------------------
// Usage:
//  in_i   carries items: cmd 0 is one 10 us tick, cmd 1 starts a frame with
//         device_address and key_code. A start while a frame runs is flagged.
//  out_o  returns one result per item: carrier level, busy, start rejected and
//         sequence done.
//  cfg_i  writes the eight timing registers by index; always ready. Write only
//         while no frame runs.
//  Latency: the result of an item is on out_o in the cycle after its transfer.
//  Throughput: one item per cycle; the state update and the next-segment
//  search of an item sit between the state registers and the result register.
//  A stalled receiver holds the result register; a new item is taken in the
//  cycle the held result is taken, so a stall only pauses the input side.
//  Reset: no frame running, timing registers at their default values, no
//  result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nec_ir_frame_transmitter_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  necirtx_cfg_if.sink    cfg_i,
  necirtx_in_if.sink     in_i,
  necirtx_out_if.source  out_o
);

  necirtx_pkg::cfg_t    cfg_q, cfg_d;
  necirtx_pkg::result_t res_q, step_res;
  logic                 out_valid_q;
  logic                 step;

  // Accept an item whenever the result register is free or being drained
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        necirtx_pkg::REG_LEADER_MARK:  cfg_d.leader_mark_ticks  = cfg_i.data[9:0];
        necirtx_pkg::REG_LEADER_SPACE: cfg_d.leader_space_ticks = cfg_i.data[9:0];
        necirtx_pkg::REG_BIT_MARK:     cfg_d.bit_mark_ticks     = cfg_i.data[7:0];
        necirtx_pkg::REG_ZERO_SPACE:   cfg_d.zero_space_ticks   = cfg_i.data[7:0];
        necirtx_pkg::REG_ONE_EXTRA:    cfg_d.one_extra_ticks    = cfg_i.data[7:0];
        necirtx_pkg::REG_REPEAT_GAP:   cfg_d.repeat_gap_ticks   = cfg_i.data[12:0];
        necirtx_pkg::REG_REPEAT_SPACE: cfg_d.repeat_space_ticks = cfg_i.data[9:0];
        necirtx_pkg::REG_END_PAUSE:    cfg_d.end_pause_ticks    = cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= necirtx_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  necirtx_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .cmd_i            (in_i.cmd),
    .device_address_i (in_i.device_address),
    .key_code_i       (in_i.key_code),
    .cfg_i            (cfg_q),
    .result_o         (step_res)
  );

  // Result register: load on an input transfer, drop on an output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (step) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.carrier_on     = res_q.carrier_on;
  assign out_o.busy_res       = res_q.busy_res;
  assign out_o.start_rejected = res_q.start_rejected;
  assign out_o.sequence_done  = res_q.sequence_done;

  `NECIRTX_ASSERT_IMP(a_rej_busy, out_valid_q && res_q.start_rejected, res_q.busy_res, "rejected start without busy")
  `NECIRTX_ASSERT_IMP(a_done_taken, out_valid_q && res_q.sequence_done, !res_q.start_rejected, "sequence done on a refused start")
  `NECIRTX_ASSERT_IMP(a_carrier_busy, out_valid_q && res_q.carrier_on, res_q.busy_res, "carrier on while not busy")

endmodule
